// ----- hdl/stpq_pkg.sv -----
`default_nettype none
package stpq_pkg;

	typedef enum logic [1:0] {
		ACT_INSERT  = 2'd0,
		ACT_REMOVE  = 2'd1,
		ACT_LIST    = 2'd2,
		ACT_INVALID = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		STAT_OK      = 2'd0,
		STAT_EMPTY   = 2'd1,
		STAT_FULL    = 2'd2,
		STAT_INVALID = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_INSERT,
		CELL_SHIFT,
		CELL_ROTATE
	} cell_op_t;

	typedef enum logic {
		S_IDLE,
		S_LIST
	} state_t;

	typedef struct packed {
		logic signed [31:0] major;
		logic signed [31:0] middle;
		logic signed [31:0] minor;
	} entry_t;

	typedef struct packed {
		logic [1:0]         action;
		logic signed [31:0] key_major;
		logic signed [31:0] key_middle;
		logic signed [31:0] key_minor;
	} req_word_t;

	typedef struct packed {
		logic signed [31:0] out_major;
		logic signed [31:0] out_middle;
		logic signed [31:0] out_minor;
		logic [5:0]         entry_count;
		logic [1:0]         status;
		logic               last;
	} rsp_word_t;

	typedef struct packed {
		cell_op_t op;
		entry_t   key;
	} cell_ctl_t;

	// a sorts strictly after b
	function automatic logic entry_greater(entry_t a, entry_t b);
		logic result;
		if (a.major != b.major)
			result = $signed(a.major) > $signed(b.major);
		else if (a.middle != b.middle)
			result = $signed(a.middle) > $signed(b.middle);
		else
			result = $signed(a.minor) > $signed(b.minor);
		return result;
	endfunction

endpackage
`default_nettype wire

// ----- hdl/stpq_cell.sv -----
`default_nettype none
module stpq_cell (
	input  wire logic              clk,
	input  wire stpq_pkg::cell_ctl_t ctl,
	input  wire logic              occupied,
	input  wire logic              wrap,
	input  wire logic              shift_left,
	input  wire stpq_pkg::entry_t  left_entry,
	input  wire stpq_pkg::entry_t  right_entry,
	input  wire stpq_pkg::entry_t  first_entry,
	output logic                   shift_here,
	output stpq_pkg::entry_t       entry_q
);

	logic greater;

	assign greater    = occupied && stpq_pkg::entry_greater(entry_q, ctl.key);
	// free cells and cells that sort after the key move right on insert
	assign shift_here = !occupied || greater;

	always_ff @(posedge clk) begin
		case (ctl.op)
			stpq_pkg::CELL_INSERT: begin
				if (shift_here)
					entry_q <= shift_left ? left_entry : ctl.key;
			end
			stpq_pkg::CELL_SHIFT:  entry_q <= right_entry;
			stpq_pkg::CELL_ROTATE: entry_q <= wrap ? first_entry : right_entry;
			default:               entry_q <= entry_q;
		endcase
	end

endmodule
`default_nettype wire

// ----- hdl/sorted_triple_priority_queue.sv -----
`default_nettype none
// Sorted min-queue of signed (major, middle, minor) triples held in a row of
// CAPACITY cells, smallest in the first cell, ties kept in arrival order.
// Insert, remove-minimum and an invalid request each give one word carrying
// the minimum and the entry count; the next request is taken once that word
// has been accepted or in the same cycle. A list request rotates the row one
// cell per accepted word, giving one word per entry in order (one empty-status
// word if the row is empty), so it holds off requests until the word for the
// last entry has been loaded. No clearing pass after reset.
module sorted_triple_priority_queue #(
	parameter int CAPACITY = 32
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                req_valid,
	output logic                     req_ready,
	input  wire stpq_pkg::req_word_t req,
	output logic                     rsp_valid,
	input  wire logic                rsp_ready,
	output stpq_pkg::rsp_word_t      rsp
);

	localparam int CNT_W = $clog2(CAPACITY + 1);

	stpq_pkg::state_t    state_q, state_d;
	logic [CNT_W-1:0]    count_q, count_d, count_m1;
	logic [CNT_W-1:0]    idx_q, idx_d;
	stpq_pkg::rsp_word_t rsp_q, rsp_d;
	logic                rsp_valid_q, rsp_load;
	stpq_pkg::cell_ctl_t ctl;
	stpq_pkg::entry_t    entries [CAPACITY];
	stpq_pkg::entry_t    key;
	logic [CAPACITY-1:0] shift_here, occupied, wrap;
	logic                req_acc, slot_free, list_step, empty, full, list_last;

	assign slot_free = !rsp_valid_q || rsp_ready;
	assign req_ready = (state_q == stpq_pkg::S_IDLE) && slot_free;
	assign req_acc   = req_valid && req_ready;
	assign list_step = (state_q == stpq_pkg::S_LIST) && slot_free;
	assign empty     = count_q == '0;
	assign full      = count_q == CNT_W'(CAPACITY);
	assign count_m1  = count_q - CNT_W'(1);
	assign list_last = idx_q == count_m1;
	assign key       = '{major: req.key_major, middle: req.key_middle, minor: req.key_minor};
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		stpq_pkg::entry_t left_e, right_e;
		logic             left_sh;

		assign occupied[i] = CNT_W'(i) < count_q;
		assign wrap[i]     = CNT_W'(i) == count_m1;

		if (i == 0) begin : g_head
			assign left_e  = key;
			assign left_sh = 1'b0;
		end else begin : g_body
			assign left_e  = entries[i-1];
			assign left_sh = shift_here[i-1];
		end

		if (i == CAPACITY - 1) begin : g_tail
			assign right_e = entries[i];
		end else begin : g_inner
			assign right_e = entries[i+1];
		end

		stpq_cell u_cell (
			.clk         (clk),
			.ctl         (ctl),
			.occupied    (occupied[i]),
			.wrap        (wrap[i]),
			.shift_left  (left_sh),
			.left_entry  (left_e),
			.right_entry (right_e),
			.first_entry (entries[0]),
			.shift_here  (shift_here[i]),
			.entry_q     (entries[i])
		);
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			stpq_pkg::S_IDLE: begin
				if (req_acc && req.action == stpq_pkg::ACT_LIST && !empty)
					state_d = stpq_pkg::S_LIST;
			end
			stpq_pkg::S_LIST: begin
				if (list_step && list_last)
					state_d = stpq_pkg::S_IDLE;
			end
			default: state_d = stpq_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		stpq_pkg::entry_t mn;
		mn       = empty ? stpq_pkg::entry_t'('0) : entries[0];
		ctl.op   = stpq_pkg::CELL_HOLD;
		ctl.key  = key;
		count_d  = count_q;
		idx_d    = idx_q;
		rsp_load = 1'b0;
		rsp_d    = rsp_q;
		rsp_d.last = 1'b1;

		if (req_acc) begin
			rsp_load = 1'b1;
			unique case (req.action)
				stpq_pkg::ACT_INSERT: begin
					if (full) begin
						rsp_d.status = stpq_pkg::STAT_FULL;
					end else begin
						ctl.op       = stpq_pkg::CELL_INSERT;
						count_d      = count_q + CNT_W'(1);
						mn           = (empty || stpq_pkg::entry_greater(entries[0], key)) ?
						               key : entries[0];
						rsp_d.status = stpq_pkg::STAT_OK;
					end
				end
				stpq_pkg::ACT_REMOVE: begin
					if (empty) begin
						rsp_d.status = stpq_pkg::STAT_EMPTY;
					end else begin
						ctl.op       = stpq_pkg::CELL_SHIFT;
						count_d      = count_m1;
						mn           = (count_m1 == '0) ? stpq_pkg::entry_t'('0) : entries[1];
						rsp_d.status = stpq_pkg::STAT_OK;
					end
				end
				stpq_pkg::ACT_LIST: begin
					rsp_load     = empty;
					idx_d        = '0;
					rsp_d.status = stpq_pkg::STAT_EMPTY;
				end
				default: begin
					rsp_d.status = stpq_pkg::STAT_INVALID;
				end
			endcase
		end else if (list_step) begin
			ctl.op       = stpq_pkg::CELL_ROTATE;
			rsp_load     = 1'b1;
			mn           = entries[0];
			rsp_d.status = stpq_pkg::STAT_OK;
			rsp_d.last   = list_last;
			idx_d        = idx_q + CNT_W'(1);
		end

		rsp_d.out_major   = mn.major;
		rsp_d.out_middle  = mn.middle;
		rsp_d.out_minor   = mn.minor;
		rsp_d.entry_count = 6'(count_d);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= stpq_pkg::S_IDLE;
			count_q     <= '0;
			idx_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			idx_q   <= idx_d;
			if (rsp_load)
				rsp_valid_q <= 1'b1;
			else if (rsp_ready)
				rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rsp_load)
			rsp_q <= rsp_d;
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(CAPACITY))
		else $error("entry count above capacity");

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == stpq_pkg::S_LIST) |-> (idx_q < count_q))
		else $error("list index past last entry");

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == stpq_pkg::S_LIST) |=> $stable(count_q))
		else $error("count changed during list");

	assert property (@(posedge clk) disable iff (!arst_n)
		(list_step && list_last) |=> (state_q == stpq_pkg::S_IDLE && rsp_valid_q && rsp_q.last))
		else $error("list did not end on last word");

endmodule
`default_nettype wire
